/* sv/gcd_by_prime_factor_merge_defines.svh */
// Assertion macros for the GCD by prime-factor merge block.
// Included by the top level; relies on its clock and reset ports.
`ifndef GCD_BY_PRIME_FACTOR_MERGE_DEFINES_SVH
`define GCD_BY_PRIME_FACTOR_MERGE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GCDPF_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gcdpf: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define GCDPF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gcdpf: next-cycle check failed");

`endif

/* sv/gcdpf_pkg.sv */
// Shared constants, types and state encoding for the GCD by prime-factor merge block.
// No dependencies; used by gcdpf_div and gcd_by_prime_factor_merge.
package gcdpf_pkg;

   // Operand width and per-operand factor list depth.
   localparam int WIDTH       = 16;
   localparam int MAX_FACTORS = 16;

   // Derived widths.
   localparam int KEPT_W = $clog2(MAX_FACTORS + 1);
   localparam int IDX_W  = $clog2(MAX_FACTORS);
   localparam int SQ_W   = WIDTH + 2;
   localparam int DCNT_W = $clog2(WIDTH);
   localparam int CNT_W  = 5;

   // Saturation value of the factor count and the first trial divisor.
   localparam logic [CNT_W-1:0] CNT_MAX = '1;
   localparam logic [WIDTH-1:0] D_FIRST = WIDTH'(2);

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CHECK,
      ST_DIVIDE,
      ST_MERGE,
      ST_DONE
   } state_type;

   // Request to the shared divider.
   typedef struct packed {
      logic             start;
      logic [WIDTH-1:0] dividend;
      logic [WIDTH-1:0] divisor;
   } div_req_type;

   // Result from the shared divider.
   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] quotient;
      logic [WIDTH-1:0] remainder;
   } div_rsp_type;

endpackage

/* sv/gcdpf_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on gcdpf_pkg for widths and the request and result structs.
module gcdpf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  gcdpf_pkg::div_req_type div_req,
   output gcdpf_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [gcdpf_pkg::DCNT_W-1:0] step_ff, step_in;
   logic [gcdpf_pkg::WIDTH-1:0]  rem_ff, rem_in;
   logic [gcdpf_pkg::WIDTH-1:0]  quo_ff, quo_in;
   logic [gcdpf_pkg::WIDTH-1:0]  dvs_ff, dvs_in;
   logic [gcdpf_pkg::WIDTH:0]    shifted;
   logic [gcdpf_pkg::WIDTH:0]    diff;

   // Shift the next dividend bit into the partial remainder and try a subtract.
   assign shifted = {rem_ff, quo_ff[gcdpf_pkg::WIDTH-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (busy_ff) begin
         // One restoring step per cycle.
         if (!diff[gcdpf_pkg::WIDTH]) begin
            rem_in = diff[gcdpf_pkg::WIDTH-1:0];
            quo_in = {quo_ff[gcdpf_pkg::WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[gcdpf_pkg::WIDTH-1:0];
            quo_in = {quo_ff[gcdpf_pkg::WIDTH-2:0], 1'b0};
         end
         step_in = step_ff - gcdpf_pkg::DCNT_W'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (div_req.start) begin
         // Load the operands; the quotient register holds the dividend bits.
         busy_in = 1'b1;
         step_in = gcdpf_pkg::DCNT_W'(gcdpf_pkg::WIDTH - 1);
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

/* sv/gcd_by_prime_factor_merge.sv */
// GCD of two unsigned operands by prime factorization and merge of the factor lists.
// Depends on gcdpf_pkg, gcdpf_div and gcd_by_prime_factor_merge_defines.svh.
//
// Usage:
//   A request is taken on the rising edge where start is high and busy is low;
//   req_operand_a and req_operand_b are sampled there. busy stays high until
//   the result has been shown.
//   The result appears on rsp_gcd_value and rsp_op_count for exactly one cycle
//   with rsp_valid high. The receiver cannot stall, so the result must be
//   captured in that cycle.
//   Each operand is factored by trial division with one shared serial divider;
//   each trial is started from a check state. Divisors run while
//   d*d <= remaining value, so a prime near 2^16 needs about 254 trials.
//   The result strobe follows the trial-division loop through the divider
//   and then the merge of the two factor lists.
//   One request is in flight at a time; busy drops in the cycle after the
//   strobe, so a new request can be taken at the end of that cycle.
//   Synchronous reset returns the sequencer to idle and drops busy and rsp_valid.
`include "gcd_by_prime_factor_merge_defines.svh"

module gcd_by_prime_factor_merge (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [15:0]                 req_operand_a,
   input  logic [15:0]                 req_operand_b,
   output logic                        rsp_valid,
   output logic [15:0]                 rsp_gcd_value,
   output logic [gcdpf_pkg::CNT_W-1:0] rsp_op_count
);

   gcdpf_pkg::state_type state_ff, state_in;

   logic                         opsel_ff, opsel_in;
   logic [gcdpf_pkg::WIDTH-1:0]  opa_ff, opa_in;
   logic [gcdpf_pkg::WIDTH-1:0]  opb_ff, opb_in;
   logic [gcdpf_pkg::WIDTH-1:0]  rest_ff, rest_in;
   logic [gcdpf_pkg::WIDTH-1:0]  d_ff, d_in;
   logic [gcdpf_pkg::SQ_W-1:0]   sq_ff, sq_in;
   logic [gcdpf_pkg::CNT_W-1:0]  cnt_ff, cnt_in;
   logic [gcdpf_pkg::KEPT_W-1:0] kept_a_ff, kept_a_in;
   logic [gcdpf_pkg::KEPT_W-1:0] kept_b_ff, kept_b_in;
   logic [gcdpf_pkg::KEPT_W-1:0] idx_i_ff, idx_i_in;
   logic [gcdpf_pkg::KEPT_W-1:0] idx_j_ff, idx_j_in;
   logic [gcdpf_pkg::WIDTH-1:0]  prod_ff, prod_in;

   logic [gcdpf_pkg::WIDTH-1:0]  list_a_ff [gcdpf_pkg::MAX_FACTORS];
   logic [gcdpf_pkg::WIDTH-1:0]  list_b_ff [gcdpf_pkg::MAX_FACTORS];

   gcdpf_pkg::div_req_type div_req;
   gcdpf_pkg::div_rsp_type div_rsp;

   logic                         sq_le_rest;
   logic                         rest_gt_one;
   logic                         exact_div;
   logic                         fac_we;
   logic [gcdpf_pkg::WIDTH-1:0]  fac_wdata;
   logic [gcdpf_pkg::KEPT_W-1:0] kept_cur;
   logic                         list_room;
   logic                         merge_live;
   logic [gcdpf_pkg::WIDTH-1:0]  fac_a;
   logic [gcdpf_pkg::WIDTH-1:0]  fac_b;
   logic [2*gcdpf_pkg::WIDTH-1:0] mul_full;

   // Shared divider for every trial division.
   gcdpf_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Loop conditions of the trial division.
   assign sq_le_rest  = sq_ff <= {2'b00, rest_ff};
   assign rest_gt_one = rest_ff > gcdpf_pkg::WIDTH'(1);
   assign exact_div   = div_rsp.done && (div_rsp.remainder == '0);

   // Factor list of the operand currently being worked on.
   assign kept_cur  = opsel_ff ? kept_b_ff : kept_a_ff;
   assign list_room = kept_cur < gcdpf_pkg::KEPT_W'(gcdpf_pkg::MAX_FACTORS);

   // Merge read ports and the product multiplier.
   assign merge_live = (idx_i_ff < kept_a_ff) && (idx_j_ff < kept_b_ff);
   assign fac_a      = list_a_ff[idx_i_ff[gcdpf_pkg::IDX_W-1:0]];
   assign fac_b      = list_b_ff[idx_j_ff[gcdpf_pkg::IDX_W-1:0]];
   assign mul_full   = {{gcdpf_pkg::WIDTH{1'b0}}, prod_ff} * {{gcdpf_pkg::WIDTH{1'b0}}, fac_a};

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gcdpf_pkg::ST_IDLE: begin
            if (start) state_in = gcdpf_pkg::ST_LOAD;
         end
         gcdpf_pkg::ST_LOAD: begin
            state_in = gcdpf_pkg::ST_CHECK;
         end
         gcdpf_pkg::ST_CHECK: begin
            if (sq_le_rest) begin
               state_in = gcdpf_pkg::ST_DIVIDE;
            end else if (!opsel_ff) begin
               state_in = gcdpf_pkg::ST_LOAD;
            end else begin
               state_in = gcdpf_pkg::ST_MERGE;
            end
         end
         gcdpf_pkg::ST_DIVIDE: begin
            if (div_rsp.done) state_in = gcdpf_pkg::ST_CHECK;
         end
         gcdpf_pkg::ST_MERGE: begin
            if (!merge_live) state_in = gcdpf_pkg::ST_DONE;
         end
         gcdpf_pkg::ST_DONE: begin
            state_in = gcdpf_pkg::ST_IDLE;
         end
         default: begin
            state_in = gcdpf_pkg::ST_IDLE;
         end
      endcase
   end

   // Control outputs of the sequencer.
   always_comb begin
      div_req.start    = 1'b0;
      div_req.dividend = rest_ff;
      div_req.divisor  = d_ff;
      fac_we           = 1'b0;
      fac_wdata        = d_ff;
      rsp_valid        = 1'b0;
      case (state_ff)
         gcdpf_pkg::ST_CHECK: begin
            div_req.start = sq_le_rest;
            // A remainder above one after the loop is itself a prime factor.
            if (!sq_le_rest && rest_gt_one) begin
               fac_we    = 1'b1;
               fac_wdata = rest_ff;
            end
         end
         gcdpf_pkg::ST_DIVIDE: begin
            fac_we = exact_div;
         end
         gcdpf_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            fac_we = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      opsel_in  = opsel_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      rest_in   = rest_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      cnt_in    = cnt_ff;
      kept_a_in = kept_a_ff;
      kept_b_in = kept_b_ff;
      idx_i_in  = idx_i_ff;
      idx_j_in  = idx_j_ff;
      prod_in   = prod_ff;

      // Every extracted factor is counted, saturating.
      if (fac_we && (cnt_ff != gcdpf_pkg::CNT_MAX)) begin
         cnt_in = cnt_ff + gcdpf_pkg::CNT_W'(1);
      end
      // Only the first MAX_FACTORS factors of each operand are kept.
      if (fac_we && list_room) begin
         if (opsel_ff) begin
            kept_b_in = kept_b_ff + gcdpf_pkg::KEPT_W'(1);
         end else begin
            kept_a_in = kept_a_ff + gcdpf_pkg::KEPT_W'(1);
         end
      end

      case (state_ff)
         gcdpf_pkg::ST_IDLE: begin
            if (start) begin
               opa_in    = req_operand_a;
               opb_in    = req_operand_b;
               opsel_in  = 1'b0;
               cnt_in    = '0;
               kept_a_in = '0;
               kept_b_in = '0;
            end
         end
         gcdpf_pkg::ST_LOAD: begin
            rest_in = opsel_ff ? opb_ff : opa_ff;
            d_in    = gcdpf_pkg::D_FIRST;
            sq_in   = gcdpf_pkg::SQ_W'(4);
         end
         gcdpf_pkg::ST_CHECK: begin
            if (!sq_le_rest) begin
               opsel_in = 1'b1;
               idx_i_in = '0;
               idx_j_in = '0;
               prod_in  = gcdpf_pkg::WIDTH'(1);
            end
         end
         gcdpf_pkg::ST_DIVIDE: begin
            if (exact_div) begin
               // Divide the factor out and retry the same divisor.
               rest_in = div_rsp.quotient;
            end else if (div_rsp.done) begin
               // Advance the divisor; (d+1)^2 = d^2 + 2d + 1.
               d_in  = d_ff + gcdpf_pkg::WIDTH'(1);
               sq_in = sq_ff + gcdpf_pkg::SQ_W'({d_ff, 1'b1});
            end
         end
         gcdpf_pkg::ST_MERGE: begin
            if (merge_live) begin
               if (fac_a == fac_b) begin
                  prod_in  = mul_full[gcdpf_pkg::WIDTH-1:0];
                  idx_i_in = idx_i_ff + gcdpf_pkg::KEPT_W'(1);
                  idx_j_in = idx_j_ff + gcdpf_pkg::KEPT_W'(1);
               end else if (fac_a < fac_b) begin
                  idx_i_in = idx_i_ff + gcdpf_pkg::KEPT_W'(1);
               end else begin
                  idx_j_in = idx_j_ff + gcdpf_pkg::KEPT_W'(1);
               end
            end
         end
         default: begin
            prod_in = prod_ff;
         end
      endcase
   end

   // Sequencer and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gcdpf_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      opsel_ff  <= opsel_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      rest_ff   <= rest_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
      cnt_ff    <= cnt_in;
      kept_a_ff <= kept_a_in;
      kept_b_ff <= kept_b_in;
      idx_i_ff  <= idx_i_in;
      idx_j_ff  <= idx_j_in;
      prod_ff   <= prod_in;
   end

   // Factor list storage, one write per extracted factor while there is room.
   always_ff @(posedge clock) begin
      if (fac_we && list_room) begin
         if (opsel_ff) begin
            list_b_ff[kept_b_ff[gcdpf_pkg::IDX_W-1:0]] <= fac_wdata;
         end else begin
            list_a_ff[kept_a_ff[gcdpf_pkg::IDX_W-1:0]] <= fac_wdata;
         end
      end
   end

   assign busy          = state_ff != gcdpf_pkg::ST_IDLE;
   assign rsp_gcd_value = prod_ff;
   assign rsp_op_count  = cnt_ff;

   // Checks on the sequencer and the result.
   `GCDPF_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy)
   `GCDPF_ASSERT_SAME(a_rsp_while_busy, rsp_valid, busy)
   `GCDPF_ASSERT_NEXT(a_rsp_single, rsp_valid, !rsp_valid && !busy)
   `GCDPF_ASSERT_SAME(a_gcd_nonzero, rsp_valid, rsp_gcd_value != '0)

endmodule

/* dv/gcd_result_checker.sv */
// Checker for the GCD by prime-factor merge block: watches requests and results,
// predicts each result by trial-division factoring, and counts mismatches.
// Depends on gcdpf_pkg for the operand width, factor list depth and count width.
`timescale 1ns / 1ps

module gcd_result_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        busy,
   input  logic [15:0]                 req_operand_a,
   input  logic [15:0]                 req_operand_b,
   input  logic                        rsp_valid,
   input  logic [15:0]                 rsp_gcd_value,
   input  logic [gcdpf_pkg::CNT_W-1:0] rsp_op_count,
   output int                          mismatch_count,
   output int                          gcd_pending
);

   // Number of mismatches reported in full; later ones are only counted.
   localparam int REPORT_LIMIT = 10;

   // One expected result, with the operands that produced it.
   typedef struct {
      logic [15:0]                 operand_a;
      logic [15:0]                 operand_b;
      logic [15:0]                 gcd_value;
      logic [gcdpf_pkg::CNT_W-1:0] op_count;
   } gcd_expect_type;

   gcd_expect_type gcd_expected_q[$];
   int             errors_seen;

   initial begin
      errors_seen = 0;
   end

   // Factor both operands, merge the two ascending lists and multiply the
   // shared factors. Only the first MAX_FACTORS factors of each operand take
   // part in the merge, but every factor is counted.
   function automatic gcd_expect_type predict_gcd(input logic [15:0] a,
                                                  input logic [15:0] b);
      longint unsigned factors [2][gcdpf_pkg::MAX_FACTORS];
      int              kept [2];
      longint unsigned mask;
      longint unsigned rest;
      longint unsigned d;
      longint unsigned prod;
      int              taken;
      int              i;
      int              j;
      gcd_expect_type  r;
      mask  = (64'd1 << gcdpf_pkg::WIDTH) - 64'd1;
      taken = 0;
      for (int k = 0; k < 2; k++) begin
         rest    = ((k == 0) ? 64'(a) : 64'(b)) & mask;
         kept[k] = 0;
         if (rest >= 2) begin
            d = 2;
            while (d * d <= rest) begin
               while (rest % d == 0) begin
                  if (kept[k] < gcdpf_pkg::MAX_FACTORS) begin
                     factors[k][kept[k]] = d;
                     kept[k]++;
                  end
                  taken++;
                  rest = rest / d;
               end
               d++;
            end
            // Whatever is left above one is a prime factor of its own.
            if (rest > 1) begin
               if (kept[k] < gcdpf_pkg::MAX_FACTORS) begin
                  factors[k][kept[k]] = rest;
                  kept[k]++;
               end
               taken++;
            end
         end
      end

      // Walk both sorted lists and keep what they share.
      prod = 1;
      i    = 0;
      j    = 0;
      while (i < kept[0] && j < kept[1]) begin
         if (factors[0][i] == factors[1][j]) begin
            prod = (prod * factors[0][i]) & mask;
            i++;
            j++;
         end else if (factors[0][i] < factors[1][j]) begin
            i++;
         end else begin
            j++;
         end
      end

      if (taken > int'(gcdpf_pkg::CNT_MAX)) begin
         taken = int'(gcdpf_pkg::CNT_MAX);
      end
      r.operand_a = a;
      r.operand_b = b;
      r.gcd_value = prod[15:0];
      r.op_count  = taken[gcdpf_pkg::CNT_W-1:0];
      return r;
   endfunction

   // Results are matched first, since a result always belongs to an earlier
   // request; then a request taken at this edge gets its expectation.
   always @(posedge clock) begin
      gcd_expect_type exp_item;
      logic           bad;
      if (!reset) begin
         if (rsp_valid) begin
            if (gcd_expected_q.size() == 0) begin
               errors_seen++;
               if (errors_seen <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result gcd=%0d count=%0d", $realtime,
                           rsp_gcd_value, rsp_op_count);
               end
            end else begin
               exp_item = gcd_expected_q.pop_front();
               bad = (rsp_gcd_value !== exp_item.gcd_value) ||
                     (rsp_op_count !== exp_item.op_count);
               if (bad) begin
                  errors_seen++;
                  if (errors_seen <= REPORT_LIMIT) begin
                     $display("%0t: a=%0d b=%0d gcd exp %0d got %0d, count exp %0d got %0d",
                              $realtime, exp_item.operand_a, exp_item.operand_b,
                              exp_item.gcd_value, rsp_gcd_value,
                              exp_item.op_count, rsp_op_count);
                  end
               end
            end
         end
         if (start && !busy) begin
            gcd_expected_q.push_back(predict_gcd(req_operand_a, req_operand_b));
         end
      end
      // Registered so that the stimulus side reads them without a race.
      mismatch_count <= errors_seen;
      gcd_pending    <= gcd_expected_q.size();
   end

endmodule

/* dv/gcd_by_prime_factor_merge_tb.sv */
// Top of the testbench for the GCD by prime-factor merge block: drives directed
// and random operand pairs in bursts and gives the verdict.
// Depends on gcdpf_pkg, the block itself and gcd_result_checker.
`timescale 1ns / 1ps

module gcd_by_prime_factor_merge_tb;

   localparam int RANDOM_ITEMS = 80;
   localparam int TAIL_CYCLES  = 20;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        start = 1'b0;
   logic                        busy;
   logic [15:0]                 req_operand_a = '0;
   logic [15:0]                 req_operand_b = '0;
   logic                        rsp_valid;
   logic [15:0]                 rsp_gcd_value;
   logic [gcdpf_pkg::CNT_W-1:0] rsp_op_count;
   int                          mismatch_count;
   int                          gcd_pending;

   gcd_by_prime_factor_merge u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_gcd_value (rsp_gcd_value),
      .rsp_op_count  (rsp_op_count)
   );

   gcd_result_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_operand_a  (req_operand_a),
      .req_operand_b  (req_operand_b),
      .rsp_valid      (rsp_valid),
      .rsp_gcd_value  (rsp_gcd_value),
      .rsp_op_count   (rsp_op_count),
      .mismatch_count (mismatch_count),
      .gcd_pending    (gcd_pending)
   );

   // 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Ends a hung run with the error verdict; the time limit leaves ample margin over the worst-case request.
   initial begin
      #50_000_000;
      $display("gcd_by_prime_factor_merge_tb: done, errors");
      $finish;
   end

   // Present one request and hold it until the block takes it.
   task automatic issue(input logic [15:0] a, input logic [15:0] b);
      start         <= 1'b1;
      req_operand_a <= a;
      req_operand_b <= b;
      do @(posedge clock); while (busy);
   endtask

   // Drop start for a number of cycles.
   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start until every outstanding result has come back.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (gcd_pending != 0);
   endtask

   // Product of random small primes, kept at or below the limit.
   function automatic int smooth_number(input int limit);
      int primes [6];
      int v;
      int p;
      int n;
      primes = '{2, 3, 5, 7, 11, 13};
      v = 1;
      n = $urandom_range(1, 16);
      repeat (n) begin
         p = primes[$urandom_range(0, 5)];
         if (v * p <= limit) begin
            v = v * p;
         end
      end
      return v;
   endfunction

   initial begin
      logic [15:0] dir_a [24];
      logic [15:0] dir_b [24];
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] special [5];
      int          g;
      int          kind;
      int          burst;
      int          gap;
      int          sent;

      // Zero and one operands, primes up to the operand value, shared and
      // disjoint factors, the longest factor lists and all-ones patterns.
      dir_a = '{16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd65535, 16'd2, 16'd2,
                16'd65521, 16'd65521, 16'd32768, 16'd32768, 16'd65535, 16'd12,
                16'd4, 16'd360, 16'd65535, 16'hFF00, 16'hAAAA, 16'd63001,
                16'd3, 16'd65534, 16'd1, 16'd7};
      dir_b = '{16'd0, 16'd1, 16'd0, 16'd1, 16'd65535, 16'd0, 16'd2, 16'd3,
                16'd65521, 16'd1, 16'd32768, 16'd65535, 16'd65535, 16'd18,
                16'd6, 16'd840, 16'd255, 16'h00FF, 16'h5555, 16'd251,
                16'd65521, 16'd32767, 16'd65521, 16'd49};
      special = '{16'd0, 16'd1, 16'd2, 16'd65521, 16'd32768};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed requests, back to back.
      for (int k = 0; k < 24; k++) begin
         issue(dir_a[k], dir_b[k]);
      end
      drain();

      // Random requests in bursts with random gaps.
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 8);
         for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
               // Shared smooth factor times random cofactors.
               g = smooth_number(255);
               a = 16'(g * $urandom_range(1, 65535 / g));
               b = 16'(g * $urandom_range(1, 65535 / g));
            end else if (kind < 60) begin
               a = 16'($urandom_range(0, 65535));
               b = 16'($urandom_range(0, 65535));
            end else if (kind < 75) begin
               a = 16'(smooth_number(65535));
               b = 16'(smooth_number(65535));
            end else if (kind < 85) begin
               a = special[$urandom_range(0, 4)];
               b = 16'($urandom_range(0, 65535));
               if ($urandom_range(0, 1) == 1) begin
                  {a, b} = {b, a};
               end
            end else begin
               a = 16'($urandom_range(0, 255));
               b = 16'($urandom_range(0, 255));
            end
            issue(a, b);
            sent++;
            if (sent == RANDOM_ITEMS / 2) begin
               drain();
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            idle_for(gap);
         end
      end

      // Wait out the last result, then a short tail for stray strobes.
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && gcd_pending == 0) begin
         $display("gcd_by_prime_factor_merge_tb: done, clean");
      end else begin
         $display("gcd_by_prime_factor_merge_tb: done, errors");
      end
      $finish;
   end

endmodule

/* files.f */
+incdir+sv
sv/gcdpf_pkg.sv
sv/gcdpf_div.sv
sv/gcd_by_prime_factor_merge.sv
dv/gcd_result_checker.sv
dv/gcd_by_prime_factor_merge_tb.sv
